@@ hdl/kbnl_pkg.sv @@
// shared types and constants for the k best neighbor list
package kbnl_pkg;

	// fixed field widths of the item and result requests
	localparam int DIST_BITS  = 32;
	localparam int INDEX_BITS = 20;
	localparam int KIND_BITS  = 2;
	localparam int SLOT_BITS  = 4;
	localparam int COUNT_BITS = 5;
	localparam int KREG_BITS  = 5;

	// k register value after reset
	localparam logic [KREG_BITS-1:0] K_RESET = KREG_BITS'(16);

	// item kinds
	typedef enum logic [KIND_BITS-1:0] {
		KIND_CLEAR = 2'd0,
		KIND_OFFER = 2'd1,
		KIND_READ  = 2'd2
	} kind_t;

	// per-cell update controls for one cycle
	typedef struct packed {
		logic load_new;
		logic shift_in;
	} cell_ctrl_t;

endpackage

@@ hdl/kbnl_if.sv @@
// valid/ready channel interfaces for items, results and the k register

interface kbnl_item_if;
	logic                             valid;
	logic                             ready;
	logic [kbnl_pkg::KIND_BITS-1:0]   kind;
	logic [kbnl_pkg::DIST_BITS-1:0]   distance;
	logic [kbnl_pkg::INDEX_BITS-1:0]  point_index;
	logic [kbnl_pkg::SLOT_BITS-1:0]   slot;

	modport source (output valid, kind, distance, point_index, slot, input ready);
	modport sink (input valid, kind, distance, point_index, slot, output ready);
endinterface

interface kbnl_result_if;
	logic                             valid;
	logic                             ready;
	logic                             accepted;
	logic [kbnl_pkg::COUNT_BITS-1:0]  count;
	logic [kbnl_pkg::DIST_BITS-1:0]   threshold;
	logic                             slot_valid;
	logic [kbnl_pkg::DIST_BITS-1:0]   slot_distance;
	logic [kbnl_pkg::INDEX_BITS-1:0]  slot_point;

	modport source (output valid, accepted, count, threshold, slot_valid, slot_distance,
		slot_point, input ready);
	modport sink (input valid, accepted, count, threshold, slot_valid, slot_distance,
		slot_point, output ready);
endinterface

interface kbnl_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [kbnl_pkg::KREG_BITS-1:0]   k_in_use;

	modport source (output valid, k_in_use, input ready);
	modport sink (input valid, k_in_use, output ready);
endinterface

@@ hdl/kbnl_cell.sv @@
// one list cell: holds an entry, compares it to the offer, loads new or left entry
module kbnl_cell (
	input  logic                             clk,
	input  logic                             held,
	input  kbnl_pkg::cell_ctrl_t             ctrl,
	input  logic [kbnl_pkg::DIST_BITS-1:0]   new_dist,
	input  logic [kbnl_pkg::INDEX_BITS-1:0]  new_point,
	input  logic [kbnl_pkg::DIST_BITS-1:0]   left_dist,
	input  logic [kbnl_pkg::INDEX_BITS-1:0]  left_point,
	output logic                             gt,
	output logic [kbnl_pkg::DIST_BITS-1:0]   dist_q,
	output logic [kbnl_pkg::INDEX_BITS-1:0]  point_q
);
	import kbnl_pkg::*;

	// offer goes behind this entry when strictly larger
	assign gt = held && (new_dist > dist_q);

	// entry storage, insert here or take the left neighbor's entry
	always_ff @(posedge clk) begin
		if (ctrl.load_new) begin
			dist_q  <= new_dist;
			point_q <= new_point;
		end else if (ctrl.shift_in) begin
			dist_q  <= left_dist;
			point_q <= left_point;
		end
	end

endmodule

@@ hdl/k_best_neighbor_list_unit.sv @@
// top level of the k best neighbor list: cell row, list control and result register
//
//  channel  dir  fields                                            handshake
//  cfg      in   k_in_use                                          valid/ready
//  item     in   kind, distance, point_index, slot                 valid/ready
//  result   out  accepted, count, threshold, slot_valid,           valid/ready
//                slot_distance, slot_point
//
// one item per cycle unless the result stalls; the result shows in the next cycle
// every cell compares and shifts in the same cycle, when the item is taken
// reset zeroes count and query index, threshold goes to all ones, k register to 16
// a stalled result holds in the output register; a new item is taken once it frees
module k_best_neighbor_list_unit #(
	parameter int MAX_K = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	kbnl_cfg_if.sink             cfg,
	kbnl_item_if.sink            item,
	kbnl_result_if.source        result
);
	import kbnl_pkg::*;

	localparam int CW = $clog2(MAX_K + 1);
	localparam int IW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
	localparam int KW = (CW > KREG_BITS) ? CW : KREG_BITS;
	localparam int SW = (CW > SLOT_BITS) ? CW : SLOT_BITS;

	// list state
	logic [CW-1:0]          held_q;
	logic [DIST_BITS-1:0]   thr_q;
	logic [INDEX_BITS-1:0]  query_q;
	logic [KREG_BITS-1:0]   k_q;

	// cell row signals
	logic [MAX_K-1:0]       gt;
	logic [DIST_BITS-1:0]   cell_dist  [MAX_K];
	logic [INDEX_BITS-1:0]  cell_point [MAX_K];
	cell_ctrl_t             cell_ctrl  [MAX_K];

	logic                   fire;
	logic [CW-1:0]          k_eff;
	logic [KW-1:0]          k_wide;
	logic [IW-1:0]          tail_idx;
	logic [IW-1:0]          prev_idx;
	logic                   offer_ok;
	logic [CW-1:0]          kept;
	logic [DIST_BITS-1:0]   tail_dist;
	logic [CW-1:0]          held_nxt;
	logic [DIST_BITS-1:0]   thr_nxt;
	logic [INDEX_BITS-1:0]  query_nxt;
	logic [SW-1:0]          slot_w;
	logic                   rd_valid;
	logic [DIST_BITS-1:0]   rd_dist;
	logic [INDEX_BITS-1:0]  rd_point;

	// result register
	logic                   res_valid_q;
	logic                   res_acc_q;
	logic [COUNT_BITS-1:0]  res_count_q;
	logic [DIST_BITS-1:0]   res_thr_q;
	logic                   res_sv_q;
	logic [DIST_BITS-1:0]   res_sd_q;
	logic [INDEX_BITS-1:0]  res_sp_q;

	assign cfg.ready  = 1'b1;
	assign item.ready = !res_valid_q || result.ready;
	assign fire       = item.valid && item.ready;

	// k register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= K_RESET;
		end else if (cfg.valid) begin
			k_q <= cfg.k_in_use;
		end
	end

	// effective k, zero acts as one, clamp to the row length
	assign k_wide = KW'(k_q);
	always_comb begin
		if (k_q == '0) begin
			k_eff = CW'(1);
		end else if (k_wide > KW'(MAX_K)) begin
			k_eff = CW'(MAX_K);
		end else begin
			k_eff = CW'(k_q);
		end
	end

	assign tail_idx = IW'(k_eff - CW'(1));
	assign prev_idx = (k_eff >= CW'(2)) ? IW'(k_eff - CW'(2)) : '0;

	// offer qualifies: other point, below threshold, lands inside the first k
	assign offer_ok = fire && (kind_t'(item.kind) == KIND_OFFER) &&
		(item.point_index != query_q) && (item.distance < thr_q) && !gt[tail_idx];

	// cell row
	for (genvar i = 0; i < MAX_K; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign cell_ctrl[i].load_new = offer_ok && !gt[i];
			assign cell_ctrl[i].shift_in = 1'b0;
			kbnl_cell u_cell (
				.clk        (clk),
				.held       (CW'(i) < held_q),
				.ctrl       (cell_ctrl[i]),
				.new_dist   (item.distance),
				.new_point  (item.point_index),
				.left_dist  (item.distance),
				.left_point (item.point_index),
				.gt         (gt[i]),
				.dist_q     (cell_dist[i]),
				.point_q    (cell_point[i])
			);
		end else begin : g_body
			assign cell_ctrl[i].load_new = offer_ok && !gt[i] && gt[i-1];
			assign cell_ctrl[i].shift_in = offer_ok && !gt[i-1];
			kbnl_cell u_cell (
				.clk        (clk),
				.held       (CW'(i) < held_q),
				.ctrl       (cell_ctrl[i]),
				.new_dist   (item.distance),
				.new_point  (item.point_index),
				.left_dist  (cell_dist[i-1]),
				.left_point (cell_point[i-1]),
				.gt         (gt[i]),
				.dist_q     (cell_dist[i]),
				.point_q    (cell_point[i])
			);
		end
	end

	// count after an insert drops whatever lies at or past the k-th slot
	assign kept = (held_q >= k_eff) ? (k_eff - CW'(1)) : held_q;
	// entry landing in the k-th slot: the offer itself or the one shifted from its left
	assign tail_dist = cell_ctrl[tail_idx].load_new ? item.distance : cell_dist[prev_idx];

	// next list state
	always_comb begin
		held_nxt  = held_q;
		thr_nxt   = thr_q;
		query_nxt = query_q;
		if (fire) begin
			unique case (kind_t'(item.kind))
				KIND_CLEAR: begin
					held_nxt  = '0;
					thr_nxt   = '1;
					query_nxt = item.point_index;
				end
				KIND_OFFER: begin
					if (offer_ok) begin
						held_nxt = kept + CW'(1);
						if (kept + CW'(1) == k_eff) begin
							thr_nxt = tail_dist;
						end
					end
				end
				KIND_READ: begin
					held_nxt = held_q;
				end
				default: begin
					held_nxt = held_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= '0;
			thr_q   <= '1;
			query_q <= '0;
		end else begin
			held_q  <= held_nxt;
			thr_q   <= thr_nxt;
			query_q <= query_nxt;
		end
	end

	// slot read
	assign slot_w   = SW'(item.slot);
	assign rd_valid = (kind_t'(item.kind) == KIND_READ) && (slot_w < SW'(held_q)) &&
		(slot_w < SW'(MAX_K));
	always_comb begin
		rd_dist  = '0;
		rd_point = '0;
		for (int i = 0; i < MAX_K; i++) begin
			if (rd_valid && (slot_w == SW'(i))) begin
				rd_dist  = cell_dist[i];
				rd_point = cell_point[i];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (item.ready) begin
			res_valid_q <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_acc_q   <= offer_ok;
			res_count_q <= COUNT_BITS'(held_nxt);
			res_thr_q   <= thr_nxt;
			res_sv_q    <= rd_valid;
			res_sd_q    <= rd_dist;
			res_sp_q    <= rd_point;
		end
	end

	assign result.valid         = res_valid_q;
	assign result.accepted      = res_acc_q;
	assign result.count         = res_count_q;
	assign result.threshold     = res_thr_q;
	assign result.slot_valid    = res_sv_q;
	assign result.slot_distance = res_sd_q;
	assign result.slot_point    = res_sp_q;

	// checks
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CW'(MAX_K))
		else $error("held count past row length");

	a_acc_count: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.accepted |-> result.count != '0)
		else $error("accepted offer with empty list");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (kind_t'(item.kind) == KIND_CLEAR) |=> (held_q == '0) && (thr_q == '1))
		else $error("clear did not empty the list");

	a_finite_full: assert property (@(posedge clk) disable iff (!arst_n)
		offer_ok && (kept + CW'(1) == k_eff) |=> thr_q == $past(tail_dist))
		else $error("threshold not taken from k-th entry");

endmodule

@@ tb/tb_top.sv @@
// self-checking testbench for the k best neighbor list unit: list predictor, scoreboard, drivers
package kbnl_tb_pkg;
	import kbnl_pkg::*;

	localparam int LIST_DEPTH = 16;
	localparam int PRINT_CAP  = 40;

	// the one kind code the block leaves unused
	localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;

	typedef struct packed {
		logic [KIND_BITS-1:0]  kind;
		logic [DIST_BITS-1:0]  distance;
		logic [INDEX_BITS-1:0] point_index;
		logic [SLOT_BITS-1:0]  slot;
	} item_req_t;

	typedef struct packed {
		logic                  accepted;
		logic [COUNT_BITS-1:0] count;
		logic [DIST_BITS-1:0]  threshold;
		logic                  slot_valid;
		logic [DIST_BITS-1:0]  slot_distance;
		logic [INDEX_BITS-1:0] slot_point;
	} reply_t;

	// sorted neighbor list mirror plus the replies still owed by the block
	class neighbor_list_board;
		logic [DIST_BITS-1:0]  dist_row [LIST_DEPTH];
		logic [INDEX_BITS-1:0] point_row [LIST_DEPTH];
		int unsigned           held;
		logic [DIST_BITS-1:0]  cutoff;
		logic [INDEX_BITS-1:0] query_id;
		logic [KREG_BITS-1:0]  k_reg;
		reply_t                awaited_replies [$];
		int unsigned           mismatches;
		int unsigned           replies_checked;
		int unsigned           clears, offers, taken, reads, read_hits, unused_kinds, k_writes;

		function new();
			foreach (dist_row[i]) begin
				dist_row[i]  = '0;
				point_row[i] = '0;
			end
			held     = 0;
			cutoff   = '1;
			query_id = '0;
			k_reg    = K_RESET;
		endfunction

		function int unsigned pending();
			return awaited_replies.size();
		endfunction

		function void load_k(logic [KREG_BITS-1:0] value);
			k_reg = value;
			k_writes++;
		endfunction

		// zero acts as one, anything past the depth acts as the depth
		function int unsigned k_limit();
			if (k_reg == 0)
				return 1;
			if (k_reg > LIST_DEPTH)
				return LIST_DEPTH;
			return k_reg;
		endfunction

		// insert ahead of equal distances, tail drops off, list is cut to k
		function bit place_entry(logic [DIST_BITS-1:0] cand_dist, logic [INDEX_BITS-1:0] pt);
			int unsigned k, n, pos, i;
			k   = k_limit();
			n   = held;
			pos = 0;
			while (pos < n && cand_dist > dist_row[pos])
				pos++;
			if (pos >= k)
				return 1'b0;
			if (n >= k)
				n = k - 1;
			for (i = n; i > pos; i--) begin
				dist_row[i]  = dist_row[i-1];
				point_row[i] = point_row[i-1];
			end
			dist_row[pos]  = cand_dist;
			point_row[pos] = pt;
			held = n + 1;
			if (held == k)
				cutoff = dist_row[k-1];
			return 1'b1;
		endfunction

		// predict the reply of one accepted request and queue it
		function void take_request(item_req_t req);
			reply_t want;
			want = '0;
			case (req.kind)
				KIND_CLEAR: begin
					held     = 0;
					cutoff   = '1;
					query_id = req.point_index;
					clears++;
				end
				KIND_OFFER: begin
					offers++;
					if (req.point_index != query_id && req.distance < cutoff)
						want.accepted = place_entry(req.distance, req.point_index);
					if (want.accepted)
						taken++;
				end
				KIND_READ: begin
					reads++;
					if (req.slot < held) begin
						want.slot_valid    = 1'b1;
						want.slot_distance = dist_row[req.slot];
						want.slot_point    = point_row[req.slot];
						read_hits++;
					end
				end
				default: begin
					unused_kinds++;
				end
			endcase
			want.count     = COUNT_BITS'(held);
			want.threshold = cutoff;
			awaited_replies.push_back(want);
		endfunction

		task report_mismatch(string what, logic [DIST_BITS-1:0] got, logic [DIST_BITS-1:0] want);
			mismatches++;
			if (mismatches <= PRINT_CAP)
				$display("reply %0d: %s is %0h, expected %0h", replies_checked, what, got, want);
		endtask

		// compare one reply field by field with the oldest prediction
		task check_reply(reply_t got);
			reply_t want;
			replies_checked++;
			if (awaited_replies.size() == 0) begin
				report_mismatch("reply with no request waiting, count", got.count, '0);
				return;
			end
			want = awaited_replies.pop_front();
			if (got.accepted !== want.accepted)
				report_mismatch("accepted", got.accepted, want.accepted);
			if (got.count !== want.count)
				report_mismatch("count", got.count, want.count);
			if (got.threshold !== want.threshold)
				report_mismatch("threshold", got.threshold, want.threshold);
			if (got.slot_valid !== want.slot_valid)
				report_mismatch("slot_valid", got.slot_valid, want.slot_valid);
			if (got.slot_distance !== want.slot_distance)
				report_mismatch("slot_distance", got.slot_distance, want.slot_distance);
			if (got.slot_point !== want.slot_point)
				report_mismatch("slot_point", got.slot_point, want.slot_point);
		endtask

		task close_out();
			if (awaited_replies.size() != 0)
				report_mismatch("requests left without a reply", awaited_replies.size(), '0);
		endtask
	endclass

endpackage

module tb_top;
	import kbnl_pkg::*;
	import kbnl_tb_pkg::*;

	localparam int RAND_PHASES     = 9;
	localparam int ITEMS_PER_PHASE = 100;
	localparam int STALL_LIMIT     = 2000;
	localparam int END_SETTLE      = 10;

	logic clk;
	logic arst_n;

	kbnl_cfg_if    cfg_bus();
	kbnl_item_if   item_bus();
	kbnl_result_if result_bus();

	k_best_neighbor_list_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.item   (item_bus),
		.result (result_bus)
	);

	neighbor_list_board     board;
	int unsigned            burst_left;
	int unsigned            query_left;
	logic [INDEX_BITS-1:0]  cur_query;
	int unsigned            rx_cycle;
	logic [1:0]             rx_mode;
	int unsigned            idle_run;
	item_req_t              seen_req;
	reply_t                 seen_reply;

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// observe handshakes on all three channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_bus.valid && cfg_bus.ready)
				board.load_k(cfg_bus.k_in_use);
			if (item_bus.valid && item_bus.ready) begin
				seen_req = {item_bus.kind, item_bus.distance, item_bus.point_index, item_bus.slot};
				board.take_request(seen_req);
			end
			if (result_bus.valid && result_bus.ready) begin
				seen_reply = {result_bus.accepted, result_bus.count, result_bus.threshold,
					result_bus.slot_valid, result_bus.slot_distance, result_bus.slot_point};
				board.check_reply(seen_reply);
			end
		end
	end

	// receiver stall pattern, with a mode that is redrawn at random
	always @(posedge clk) begin
		rx_cycle++;
		if (rx_cycle % 97 == 0)
			rx_mode = 2'($urandom_range(0, 3));
		case (rx_mode)
			2'd0: result_bus.ready <= 1'b1;
			2'd1: result_bus.ready <= ($urandom_range(0, 9) < 7);
			2'd2: result_bus.ready <= ((rx_cycle % 8) >= 5);
			default: result_bus.ready <= ((rx_cycle % 16) >= 12);
		endcase
	end

	// watchdog on cycles with no request moving anywhere
	always @(posedge clk) begin
		if (!arst_n || (cfg_bus.valid && cfg_bus.ready) || (item_bus.valid && item_bus.ready) ||
				(result_bus.valid && result_bus.ready))
			idle_run = 0;
		else
			idle_run++;
		if (idle_run >= STALL_LIMIT) begin
			$display("watchdog: no request moved for %0d cycles", idle_run);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function item_req_t make_request(logic [KIND_BITS-1:0] kind, logic [DIST_BITS-1:0] dist_val,
			logic [INDEX_BITS-1:0] pt, logic [SLOT_BITS-1:0] slot);
		item_req_t r;
		r.kind        = kind;
		r.distance    = dist_val;
		r.point_index = pt;
		r.slot        = slot;
		return r;
	endfunction

	// mostly query runs of offers and reads, some noise and early clears
	function item_req_t random_request();
		item_req_t   r;
		int unsigned pick;
		r.distance    = $urandom;
		r.point_index = INDEX_BITS'($urandom_range(0, 20'hFFFFF));
		r.slot        = SLOT_BITS'($urandom_range(0, 15));
		pick = $urandom_range(0, 99);
		if (query_left == 0 || pick < 3) begin
			r.kind = KIND_CLEAR;
			if ($urandom_range(0, 3) == 0)
				r.point_index = INDEX_BITS'($urandom_range(0, 15));
			cur_query  = r.point_index;
			query_left = $urandom_range(6, 60);
		end else begin
			query_left--;
			if (pick < 68) begin
				r.kind = KIND_OFFER;
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: r.distance = $urandom_range(0, 255);
					5, 6, 7: ;
					8: r.distance = $urandom_range(0, 15);
					default: r.distance = $urandom_range(0, 1) ? '1 : '0;
				endcase
				case ($urandom_range(0, 19))
					0, 1: r.point_index = cur_query;
					2: r.point_index = INDEX_BITS'($urandom_range(0, 15));
					default: ;
				endcase
			end else if (pick < 95) begin
				r.kind = KIND_READ;
			end else begin
				r.kind = KIND_UNUSED;
			end
		end
		return r;
	endfunction

	function logic [KREG_BITS-1:0] pick_k();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return KREG_BITS'($urandom_range(1, 4));
			4, 5: return KREG_BITS'(LIST_DEPTH);
			6: return KREG_BITS'(1);
			7: return KREG_BITS'($urandom_range(0, 31));
			8: return KREG_BITS'($urandom_range(5, 15));
			default: return $urandom_range(0, 1) ? KREG_BITS'(0) : KREG_BITS'(31);
		endcase
	endfunction

	// drive one request, then end the burst with a gap when it runs out
	task send_request(input item_req_t r);
		item_bus.valid       <= 1'b1;
		item_bus.kind        <= r.kind;
		item_bus.distance    <= r.distance;
		item_bus.point_index <= r.point_index;
		item_bus.slot        <= r.slot;
		do @(posedge clk); while (!item_bus.ready);
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			item_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 48);
		end
	endtask

	// hold off the sender until every predicted reply has come back
	task drain_requests();
		item_bus.valid <= 1'b0;
		do @(posedge clk); while (board.pending() != 0);
	endtask

	// write the k register once the block is idle
	task set_k(input logic [KREG_BITS-1:0] value);
		drain_requests();
		cfg_bus.valid    <= 1'b1;
		cfg_bus.k_in_use <= value;
		do @(posedge clk); while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
	endtask

	// stimulus
	initial begin
		int ph;
		int n;
		board      = new();
		burst_left = $urandom_range(1, 48);
		query_left = 0;
		cur_query  = '0;
		rx_cycle   = 0;
		rx_mode    = 2'd0;
		idle_run   = 0;

		arst_n               <= 1'b0;
		cfg_bus.valid        <= 1'b0;
		cfg_bus.k_in_use     <= '0;
		item_bus.valid       <= 1'b0;
		item_bus.kind        <= '0;
		item_bus.distance    <= '0;
		item_bus.point_index <= '0;
		item_bus.slot        <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// offers before any clear see query point zero
		send_request(make_request(KIND_OFFER, 32'd100, 20'd0, 4'd0));
		send_request(make_request(KIND_OFFER, 32'd100, 20'd5, 4'd0));
		send_request(make_request(KIND_READ, 32'd0, 20'd0, 4'd0));
		send_request(make_request(KIND_UNUSED, '1, '1, 4'd15));
		// new query: own index, infinite distance, extremes, equal distances
		send_request(make_request(KIND_CLEAR, 32'd0, 20'd7, 4'd0));
		send_request(make_request(KIND_OFFER, 32'd10, 20'd7, 4'd0));
		send_request(make_request(KIND_OFFER, '1, 20'd1, 4'd0));
		send_request(make_request(KIND_OFFER, 32'hFFFF_FFFE, 20'hFFFFF, 4'd0));
		send_request(make_request(KIND_OFFER, 32'd0, 20'd2, 4'd0));
		send_request(make_request(KIND_OFFER, 32'd50, 20'd3, 4'd0));
		send_request(make_request(KIND_OFFER, 32'd50, 20'd4, 4'd0));
		send_request(make_request(KIND_READ, 32'd0, 20'd0, 4'd1));
		send_request(make_request(KIND_READ, 32'd0, 20'd0, 4'd2));
		send_request(make_request(KIND_READ, 32'd0, 20'd0, 4'd15));
		send_request(make_request(KIND_READ, 32'd0, 20'd0, 4'd3));
		// k lowered mid-query: insert past the end, then the list is cut
		set_k(KREG_BITS'(2));
		send_request(make_request(KIND_OFFER, 32'd60, 20'd8, 4'd0));
		send_request(make_request(KIND_OFFER, 32'd20, 20'd9, 4'd0));
		send_request(make_request(KIND_READ, 32'd0, 20'd0, 4'd1));
		send_request(make_request(KIND_READ, 32'd0, 20'd0, 4'd3));
		// zero acts as one
		set_k(KREG_BITS'(0));
		send_request(make_request(KIND_OFFER, 32'd5, 20'd10, 4'd0));
		send_request(make_request(KIND_OFFER, 32'd5, 20'd11, 4'd0));
		// above the depth acts as the depth
		set_k(KREG_BITS'(31));
		send_request(make_request(KIND_OFFER, 32'd1, 20'd12, 4'd0));
		send_request(make_request(KIND_CLEAR, 32'd0, 20'hFFFFF, 4'd0));
		set_k(KREG_BITS'(17));
		send_request(make_request(KIND_OFFER, 32'd3, 20'd0, 4'd0));

		// random phases, each opened by a k write on an idle block
		for (ph = 0; ph < RAND_PHASES; ph++) begin
			set_k(pick_k());
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				if ($urandom_range(0, 149) == 0)
					drain_requests();
				send_request(random_request());
			end
		end

		drain_requests();
		repeat (END_SETTLE) @(posedge clk);
		board.close_out();

		$display("covered %0d clears, %0d offers (%0d entered), %0d reads (%0d held), %0d unused",
			board.clears, board.offers, board.taken, board.reads, board.read_hits,
			board.unused_kinds);
		$display("k register written %0d times incl. out-of-range values; %0d replies checked",
			board.k_writes, board.replies_checked);
		if (board.mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ k_best_neighbor_list_unit.f @@
hdl/kbnl_pkg.sv
hdl/kbnl_if.sv
hdl/kbnl_cell.sv
hdl/k_best_neighbor_list_unit.sv
tb/tb_top.sv
